/* design/i2cms_pkg.sv */
// Shared types and constants for the two-wire master transfer sequencer.
`default_nettype none
package i2cms_pkg;

    localparam int BUF_DEPTH_DEF = 64;

    typedef enum logic [2:0] {
        CMD_LOAD       = 3'd0,
        CMD_READ_BACK  = 3'd1,
        CMD_START_WR   = 3'd2,
        CMD_START_RD   = 3'd3,
        CMD_START_REG  = 3'd4,
        CMD_EVENT      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SEND_NEXT = 3'd1,
        PH_SEND_LAST = 3'd2,
        PH_AWAIT     = 3'd3,
        PH_RX_NEXT   = 3'd4,
        PH_RX_NTL    = 3'd5,
        PH_RX_LAST   = 3'd6,
        PH_ERROR     = 3'd7
    } phase_t;

    // Decoded result of one item, before the store byte is merged in.
    typedef struct packed {
        logic       set_mode;
        logic [6:0] target_address;
        logic       read_mode;
        logic       internal_address_used;
        logic       issue_start;
        logic       issue_stop;
        logic       tx_valid;
        logic       data_from_store;
        logic       events_off;
        phase_t     phase;
        logic [5:0] remaining_count;
    } stage_t;

    // Complete result item as presented on the output channel.
    typedef struct packed {
        logic       set_mode;
        logic [6:0] target_address;
        logic       read_mode;
        logic       internal_address_used;
        logic [7:0] internal_address;
        logic       issue_start;
        logic       issue_stop;
        logic       tx_valid;
        logic [7:0] data_byte;
        logic       events_off;
        phase_t     phase;
        logic [5:0] remaining_count;
    } result_t;

endpackage
`default_nettype wire

/* design/i2c_master_transfer_sequencer.sv */
// Top level of the two-wire master transfer sequencer.
// Takes one command or core event per cycle while s_ready is high and returns exactly one result item for each.
// On acceptance the transfer state and stage register are updated and the byte store access
// is issued; the stage register and registered store read data then merge into the result
// register. The sustained rate is one item per cycle;
// a full result register stalls the input only when the result side is not taking items.
// The byte store has no reset; reading an entry before it is loaded returns undefined data.
`default_nettype none
module i2c_master_transfer_sequencer #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_command,
    input  wire logic [6:0] s_device_address,
    input  wire logic [5:0] s_byte_count,
    input  wire logic [5:0] s_buffer_index,
    input  wire logic [7:0] s_buffer_value,
    input  wire logic       s_arbitration_lost,
    input  wire logic       s_nack_seen,
    input  wire logic [7:0] s_received_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_set_mode,
    output logic [6:0]      m_target_address,
    output logic            m_read_mode,
    output logic            m_internal_address_used,
    output logic [7:0]      m_internal_address,
    output logic            m_issue_start,
    output logic            m_issue_stop,
    output logic            m_tx_valid,
    output logic [7:0]      m_data_byte,
    output logic            m_events_off,
    output logic [2:0]      m_phase,
    output logic [5:0]      m_remaining_count
);

    localparam int AW = $clog2(BUF_DEPTH);

    logic              accept;
    logic              stage_valid;
    logic              stage_ready;
    i2cms_pkg::stage_t stage;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic              m_valid_reg, m_valid_next;
    i2cms_pkg::result_t res_reg, res_next;

    assign stage_ready = !m_valid_reg || m_ready;
    assign s_ready     = !stage_valid || stage_ready;
    assign accept      = s_valid && s_ready;

    i2cms_ctrl #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .command          (s_command),
        .device_address   (s_device_address),
        .byte_count       (s_byte_count),
        .buffer_index     (s_buffer_index),
        .buffer_value     (s_buffer_value),
        .arbitration_lost (s_arbitration_lost),
        .nack_seen        (s_nack_seen),
        .received_byte    (s_received_byte),
        .stage_ready      (stage_ready),
        .stage_valid      (stage_valid),
        .stage            (stage),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr)
    );

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        res_next.set_mode              = stage.set_mode;
        res_next.target_address        = stage.target_address;
        res_next.read_mode             = stage.read_mode;
        res_next.internal_address_used = stage.internal_address_used;
        res_next.internal_address      = stage.internal_address_used ? ram_rdata : 8'h00;
        res_next.issue_start           = stage.issue_start;
        res_next.issue_stop            = stage.issue_stop;
        res_next.tx_valid              = stage.tx_valid;
        res_next.data_byte             = stage.data_from_store ? ram_rdata : 8'h00;
        res_next.events_off            = stage.events_off;
        res_next.phase                 = stage.phase;
        res_next.remaining_count       = stage.remaining_count;
    end

    always_comb begin
        if (stage_valid && stage_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // load the result only when the stage moves forward
    always_ff @(posedge aclk) begin
        if (stage_valid && stage_ready) begin
            res_reg <= res_next;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_set_mode              = res_reg.set_mode;
    assign m_target_address        = res_reg.target_address;
    assign m_read_mode             = res_reg.read_mode;
    assign m_internal_address_used = res_reg.internal_address_used;
    assign m_internal_address      = res_reg.internal_address;
    assign m_issue_start           = res_reg.issue_start;
    assign m_issue_stop            = res_reg.issue_stop;
    assign m_tx_valid              = res_reg.tx_valid;
    assign m_data_byte             = res_reg.data_byte;
    assign m_events_off            = res_reg.events_off;
    assign m_phase                 = res_reg.phase;
    assign m_remaining_count       = res_reg.remaining_count;

endmodule
`default_nettype wire

/* design/i2cms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = i2cms_pkg::BUF_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/i2cms_ctrl.sv */
// Command decode, transfer state and first pipeline stage of the sequencer.
`default_nettype none
module i2cms_ctrl #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF,
    localparam int AW = $clog2(BUF_DEPTH)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [2:0]          command,
    input  wire logic [6:0]          device_address,
    input  wire logic [5:0]          byte_count,
    input  wire logic [5:0]          buffer_index,
    input  wire logic [7:0]          buffer_value,
    input  wire logic                arbitration_lost,
    input  wire logic                nack_seen,
    input  wire logic [7:0]          received_byte,
    input  wire logic                stage_ready,
    output logic                     stage_valid,
    output i2cms_pkg::stage_t        stage,
    output logic                     ram_we,
    output logic [AW-1:0]            ram_waddr,
    output logic [7:0]               ram_wdata,
    output logic                     ram_re,
    output logic [AW-1:0]            ram_raddr
);

    i2cms_pkg::phase_t phase_reg, phase_next;
    logic [5:0]        count_reg, count_next;
    logic [AW-1:0]     pointer_reg, pointer_next;
    logic              stage_valid_reg, stage_valid_next;
    i2cms_pkg::stage_t stage_reg, stage_next;

    logic [AW-1:0]     idx_wrapped;
    logic [AW-1:0]     pointer_inc;
    logic [5:0]        count_dec;
    logic [5:0]        rd_count;
    i2cms_pkg::phase_t ev_phase;

    // Reduce a buffer index by up to eight subtractions of the store depth.
    function automatic logic [AW-1:0] wrap_idx(input logic [5:0] i);
        logic [8:0] v;
        v = {3'b000, i};
        for (int k = 0; k < 8; k++) begin
            if (v >= 9'(BUF_DEPTH)) begin
                v = v - 9'(BUF_DEPTH);
            end
        end
        return v[AW-1:0];
    endfunction

    function automatic i2cms_pkg::phase_t rx_phase_for(input logic [5:0] n);
        if (n == 6'd1) begin
            return i2cms_pkg::PH_RX_LAST;
        end else if (n == 6'd2) begin
            return i2cms_pkg::PH_RX_NTL;
        end
        return i2cms_pkg::PH_RX_NEXT;
    endfunction

    assign idx_wrapped = wrap_idx(buffer_index);
    assign pointer_inc = (pointer_reg == AW'(BUF_DEPTH - 1)) ? '0 : pointer_reg + 1'b1;
    assign count_dec   = count_reg - 6'd1;
    assign rd_count    = (byte_count == 6'd0) ? 6'd1 : byte_count;
    // error flags override the running phase
    assign ev_phase    = (arbitration_lost || nack_seen) ? i2cms_pkg::PH_ERROR : phase_reg;

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        pointer_next = pointer_reg;
        stage_next   = '0;
        ram_we       = 1'b0;
        ram_waddr    = pointer_reg;
        ram_wdata    = received_byte;
        ram_re       = 1'b0;
        ram_raddr    = pointer_reg;

        case (i2cms_pkg::cmd_t'(command))
            i2cms_pkg::CMD_LOAD: begin
                ram_we    = accept;
                ram_waddr = idx_wrapped;
                ram_wdata = buffer_value;
            end
            i2cms_pkg::CMD_READ_BACK: begin
                ram_re    = accept;
                ram_raddr = idx_wrapped;
                stage_next.data_from_store = 1'b1;
            end
            i2cms_pkg::CMD_START_WR: begin
                stage_next.set_mode        = 1'b1;
                stage_next.target_address  = device_address;
                stage_next.tx_valid        = 1'b1;
                stage_next.data_from_store = 1'b1;
                ram_re       = accept;
                ram_raddr    = '0;
                count_next   = byte_count;
                pointer_next = AW'(1);
                if (byte_count == 6'd0) begin
                    phase_next = i2cms_pkg::PH_AWAIT;
                end else if (byte_count == 6'd1) begin
                    phase_next = i2cms_pkg::PH_SEND_LAST;
                end else begin
                    phase_next = i2cms_pkg::PH_SEND_NEXT;
                end
            end
            i2cms_pkg::CMD_START_RD, i2cms_pkg::CMD_START_REG: begin
                stage_next.set_mode       = 1'b1;
                stage_next.target_address = device_address;
                stage_next.read_mode      = 1'b1;
                stage_next.issue_start    = 1'b1;
                stage_next.issue_stop     = (rd_count == 6'd1);
                if (i2cms_pkg::cmd_t'(command) == i2cms_pkg::CMD_START_REG) begin
                    stage_next.internal_address_used = 1'b1;
                    ram_re    = accept;
                    ram_raddr = '0;
                end
                count_next   = rd_count;
                pointer_next = '0;
                phase_next   = rx_phase_for(rd_count);
            end
            i2cms_pkg::CMD_EVENT: begin
                stage_next.issue_stop = arbitration_lost;
                phase_next = ev_phase;
                case (ev_phase)
                    i2cms_pkg::PH_SEND_NEXT: begin
                        stage_next.tx_valid        = 1'b1;
                        stage_next.data_from_store = 1'b1;
                        ram_re       = accept;
                        pointer_next = pointer_inc;
                        count_next   = count_dec;
                        if (count_dec == 6'd1) begin
                            phase_next = i2cms_pkg::PH_SEND_LAST;
                        end
                    end
                    i2cms_pkg::PH_SEND_LAST: begin
                        stage_next.tx_valid        = 1'b1;
                        stage_next.data_from_store = 1'b1;
                        stage_next.issue_stop      = 1'b1;
                        ram_re     = accept;
                        phase_next = i2cms_pkg::PH_AWAIT;
                    end
                    i2cms_pkg::PH_AWAIT: begin
                        stage_next.events_off = 1'b1;
                        count_next = '0;
                        phase_next = i2cms_pkg::PH_IDLE;
                    end
                    i2cms_pkg::PH_RX_NEXT: begin
                        ram_we       = accept;
                        pointer_next = pointer_inc;
                        count_next   = count_dec;
                        if (count_dec == 6'd2) begin
                            phase_next = i2cms_pkg::PH_RX_NTL;
                        end
                    end
                    i2cms_pkg::PH_RX_NTL: begin
                        ram_we       = accept;
                        pointer_next = pointer_inc;
                        stage_next.issue_stop = 1'b1;
                        count_next   = count_dec;
                        phase_next   = i2cms_pkg::PH_RX_LAST;
                    end
                    i2cms_pkg::PH_RX_LAST: begin
                        ram_we     = accept;
                        stage_next.events_off = 1'b1;
                        count_next = '0;
                        phase_next = i2cms_pkg::PH_IDLE;
                    end
                    default: begin
                        // idle or error: shut off core events (a stop is still issued on arbitration loss)
                        stage_next.events_off = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase

        stage_next.phase           = phase_next;
        stage_next.remaining_count = count_next;
    end

    always_comb begin
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (stage_ready) begin
            stage_valid_next = 1'b0;
        end else begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= i2cms_pkg::PH_IDLE;
            count_reg       <= '0;
            pointer_reg     <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            if (accept) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                pointer_reg <= pointer_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule
`default_nettype wire

/* design/i2cms_checker.sv */
// Port-level assertions for the transfer sequencer, bound to the top level.
`default_nettype none
module i2cms_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_set_mode,
    input wire logic       m_read_mode,
    input wire logic       m_issue_start,
    input wire logic       m_tx_valid,
    input wire logic [7:0] m_data_byte,
    input wire logic       m_events_off,
    input wire logic [2:0] m_phase,
    input wire logic [5:0] m_remaining_count
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_byte) && $stable(m_phase)
            && $stable(m_remaining_count))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // events are only disabled when a transfer has ended
    a_events_off_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_events_off |-> m_phase == i2cms_pkg::PH_IDLE
            || m_phase == i2cms_pkg::PH_ERROR)
        else $error("events disabled in an active phase");

    a_tx_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid |-> m_phase == i2cms_pkg::PH_SEND_NEXT
            || m_phase == i2cms_pkg::PH_SEND_LAST || m_phase == i2cms_pkg::PH_AWAIT)
        else $error("transmit byte outside a write");

    a_read_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_mode |-> m_set_mode && m_issue_start)
        else $error("read mode without start");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_set_mode        (m_set_mode),
    .m_read_mode       (m_read_mode),
    .m_issue_start     (m_issue_start),
    .m_tx_valid        (m_tx_valid),
    .m_data_byte       (m_data_byte),
    .m_events_off      (m_events_off),
    .m_phase           (m_phase),
    .m_remaining_count (m_remaining_count)
);
`default_nettype wire
